[design/assert_macros.svh]
// Assertion macros for the design files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies another one in the same cycle.
`define ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("Same-cycle assertion failed.");

// Checks that a condition implies another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("Next-cycle assertion failed.");

`endif

[design/es2ct_pkg.sv]
// Package with the types, constants and month table of the civil time converter.
package es2ct_pkg;

   localparam int unsigned SecondsPerDay  = 86400;
   localparam int unsigned SecondsPerHour = 3600;
   localparam int unsigned SecondsPerMin  = 60;
   localparam int unsigned EpochYearOff   = 70;
   localparam int unsigned DivWidth       = 32;
   localparam int unsigned QuoWidth       = 16;
   localparam int unsigned RemWidth       = 17;
   localparam int unsigned MulWidth       = 26;

   // A divisor 2^s * c is applied as ((x >> s) * ceil(2^k / c)) >> k, exact over the range.
   localparam int unsigned DayPreShift   = 7;
   localparam int unsigned DayRecip      = 50903317;
   localparam int unsigned DayPostShift  = 35;
   localparam int unsigned HourPreShift  = 4;
   localparam int unsigned HourRecip     = 9321;
   localparam int unsigned HourPostShift = 21;
   localparam int unsigned MinPreShift   = 2;
   localparam int unsigned MinRecip      = 1093;
   localparam int unsigned MinPostShift  = 14;

   localparam logic [3:0] MonthFeb  = 4'd1;
   localparam logic [3:0] MonthApr  = 4'd3;
   localparam logic [3:0] MonthJun  = 4'd5;
   localparam logic [3:0] MonthSep  = 4'd8;
   localparam logic [3:0] MonthNov  = 4'd10;
   localparam logic [3:0] MonthLast = 4'd11;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_DAY,
      ST_DIV_HOUR,
      ST_DIV_MIN,
      ST_YEAR,
      ST_MONTH,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      DIV_BY_DAY,
      DIV_BY_HOUR,
      DIV_BY_MIN
   } div_sel_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_RECIP,
      PH_BACK,
      PH_REM
   } div_phase_type;

   typedef struct packed {
      logic                start;
      div_sel_type         sel;
      logic [DivWidth-1:0] dividend;
   } div_cmd_type;

   typedef struct packed {
      logic                done;
      logic [QuoWidth-1:0] quotient;
      logic [RemWidth-1:0] remainder;
   } div_res_type;

   // Years are counted from 1900; only 2000 among the centuries in range is leap.
   function automatic logic leap_year(input logic [7:0] year_off);
      leap_year = (year_off[1:0] == 2'd0) && (year_off != 8'd0) && (year_off != 8'd200);
   endfunction

   function automatic logic [4:0] month_days(input logic leap, input logic [3:0] month);
      logic [4:0] len;
      len = 5'd31;
      case (month)
         MonthFeb: len = leap ? 5'd29 : 5'd28;
         MonthApr, MonthJun, MonthSep, MonthNov: len = 5'd30;
         default: len = 5'd31;
      endcase
      month_days = len;
   endfunction

endpackage

[design/es2ct_div.sv]
// Shared divider by a day, an hour or a minute, built on one reciprocal multiplier.
module es2ct_div
   import es2ct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_res_type res
);

   div_phase_type         phase_ff, phase_in;
   div_sel_type           sel_ff, sel_in;
   logic [DivWidth-1:0]   num_ff, num_in;
   logic [2*MulWidth-1:0] prod_ff, prod_in;
   logic [QuoWidth-1:0]   quo_ff, quo_in;
   logic [RemWidth-1:0]   rem_ff, rem_in;
   logic                  done_ff, done_in;
   logic [MulWidth-1:0]   scaled;
   logic [MulWidth-1:0]   recip;
   logic [MulWidth-1:0]   divisor;
   logic [QuoWidth-1:0]   quo;
   logic [MulWidth-1:0]   mul_a;
   logic [MulWidth-1:0]   mul_b;
   logic [2*MulWidth-1:0] product;

   always_comb begin
      case (sel_ff)
         DIV_BY_HOUR: begin
            scaled  = MulWidth'(num_ff >> HourPreShift);
            recip   = MulWidth'(HourRecip);
            divisor = MulWidth'(SecondsPerHour);
            quo     = QuoWidth'(prod_ff >> HourPostShift);
         end
         DIV_BY_MIN: begin
            scaled  = MulWidth'(num_ff >> MinPreShift);
            recip   = MulWidth'(MinRecip);
            divisor = MulWidth'(SecondsPerMin);
            quo     = QuoWidth'(prod_ff >> MinPostShift);
         end
         default: begin
            scaled  = MulWidth'(num_ff >> DayPreShift);
            recip   = MulWidth'(DayRecip);
            divisor = MulWidth'(SecondsPerDay);
            quo     = QuoWidth'(prod_ff >> DayPostShift);
         end
      endcase
      mul_a = scaled;
      mul_b = recip;
      if (phase_ff == PH_BACK) begin
         mul_a = MulWidth'(quo);
         mul_b = divisor;
      end
      product  = {{MulWidth{1'b0}}, mul_a} * {{MulWidth{1'b0}}, mul_b};
      phase_in = phase_ff;
      sel_in   = sel_ff;
      num_in   = num_ff;
      prod_in  = prod_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         phase_in = PH_RECIP;
         sel_in   = cmd.sel;
         num_in   = cmd.dividend;
      end else begin
         case (phase_ff)
            PH_RECIP: begin
               prod_in  = product;
               phase_in = PH_BACK;
            end
            PH_BACK: begin
               quo_in   = quo;
               prod_in  = product;
               phase_in = PH_REM;
            end
            PH_REM: begin
               rem_in   = RemWidth'(num_ff - prod_ff[DivWidth-1:0]);
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      sel_ff  <= sel_in;
      num_ff  <= num_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign res.done      = done_ff;
   assign res.quotient  = quo_ff;
   assign res.remainder = rem_ff;

endmodule

[design/epoch_seconds_to_civil_time_top.sv]
// Top level of the converter from epoch seconds to broken-down UTC calendar time.
// The req channel takes one word with a 32-bit count of seconds since 1970-01-01.
// The rsp channel returns one word per request with second, minute, hour, day of
// month, month, years since 1900 and day of year.
// One shared reciprocal multiplier splits the seconds into days, hours, minutes
// and seconds. The year is then found by removing one year length per cycle,
// and the month by removing one month length per cycle. Only one request is in
// work at a time; req_ready is high while the block is idle, which includes the
// time a finished word waits in the output register. A new request can be
// accepted as soon as rsp_valid rises. When the receiver stalls, a finished
// conversion waits until the output register is free. Reset clears the
// sequencer and drops rsp_valid.
module epoch_seconds_to_civil_time_top
   import es2ct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_second_of_minute,
   output logic [5:0]  rsp_minute_of_hour,
   output logic [4:0]  rsp_hour_of_day,
   output logic [4:0]  rsp_day_of_month,
   output logic [3:0]  rsp_month_index,
   output logic [7:0]  rsp_years_since_1900,
   output logic [8:0]  rsp_day_of_year
);

`include "assert_macros.svh"

   state_type   state_ff, state_in;
   logic [15:0] days_ff, days_in;
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  hour_ff, hour_in;
   logic [7:0]  year_ff, year_in;
   logic [8:0]  yday_ff, yday_in;
   logic [3:0]  month_ff, month_in;
   logic        leap_ff, leap_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  o_sec_ff, o_sec_in;
   logic [5:0]  o_min_ff, o_min_in;
   logic [4:0]  o_hour_ff, o_hour_in;
   logic [4:0]  o_mday_ff, o_mday_in;
   logic [3:0]  o_month_ff, o_month_in;
   logic [7:0]  o_year_ff, o_year_in;
   logic [8:0]  o_yday_ff, o_yday_in;
   div_cmd_type div_cmd;
   div_res_type div_res;
   logic        cur_leap;
   logic [8:0]  year_len;
   logic [4:0]  mon_len;
   logic        in_div_state;
   logic        walk_bounded;
   logic        time_legal;

   es2ct_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   always_comb begin
      cur_leap     = leap_year(year_ff);
      year_len     = 9'd365 + {8'd0, cur_leap};
      mon_len      = month_days(leap_ff, month_ff);
      state_in     = state_ff;
      days_in      = days_ff;
      sec_in       = sec_ff;
      min_in       = min_ff;
      hour_in      = hour_ff;
      year_in      = year_ff;
      yday_in      = yday_ff;
      month_in     = month_ff;
      leap_in      = leap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      o_sec_in     = o_sec_ff;
      o_min_in     = o_min_ff;
      o_hour_in    = o_hour_ff;
      o_mday_in    = o_mday_ff;
      o_month_in   = o_month_ff;
      o_year_in    = o_year_ff;
      o_yday_in    = o_yday_ff;
      div_cmd          = '0;
      req_ready        = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               div_cmd.start    = 1'b1;
               div_cmd.sel      = DIV_BY_DAY;
               div_cmd.dividend = req_epoch_seconds;
               state_in         = ST_DIV_DAY;
            end
         end
         ST_DIV_DAY: begin
            if (div_res.done) begin
               days_in          = div_res.quotient;
               div_cmd.start    = 1'b1;
               div_cmd.sel      = DIV_BY_HOUR;
               div_cmd.dividend = DivWidth'(div_res.remainder);
               state_in         = ST_DIV_HOUR;
            end
         end
         ST_DIV_HOUR: begin
            if (div_res.done) begin
               hour_in          = div_res.quotient[4:0];
               div_cmd.start    = 1'b1;
               div_cmd.sel      = DIV_BY_MIN;
               div_cmd.dividend = DivWidth'(div_res.remainder);
               state_in         = ST_DIV_MIN;
            end
         end
         ST_DIV_MIN: begin
            if (div_res.done) begin
               min_in   = div_res.quotient[5:0];
               sec_in   = div_res.remainder[5:0];
               year_in  = 8'(EpochYearOff);
               state_in = ST_YEAR;
            end
         end
         ST_YEAR: begin
            if (days_ff < {7'd0, year_len}) begin
               yday_in  = days_ff[8:0];
               leap_in  = cur_leap;
               month_in = '0;
               state_in = ST_MONTH;
            end else begin
               days_in = days_ff - {7'd0, year_len};
               year_in = year_ff + 8'd1;
            end
         end
         ST_MONTH: begin
            if ((month_ff < MonthLast) && (days_ff >= {11'd0, mon_len})) begin
               days_in  = days_ff - {11'd0, mon_len};
               month_in = month_ff + 4'd1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               o_sec_in     = sec_ff;
               o_min_in     = min_ff;
               o_hour_in    = hour_ff;
               o_mday_in    = days_ff[4:0] + 5'd1;
               o_month_in   = month_ff;
               o_year_in    = year_ff;
               o_yday_in    = yday_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      days_ff    <= days_in;
      sec_ff     <= sec_in;
      min_ff     <= min_in;
      hour_ff    <= hour_in;
      year_ff    <= year_in;
      yday_ff    <= yday_in;
      month_ff   <= month_in;
      leap_ff    <= leap_in;
      o_sec_ff   <= o_sec_in;
      o_min_ff   <= o_min_in;
      o_hour_ff  <= o_hour_in;
      o_mday_ff  <= o_mday_in;
      o_month_ff <= o_month_in;
      o_year_ff  <= o_year_in;
      o_yday_ff  <= o_yday_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_second_of_minute = o_sec_ff;
   assign rsp_minute_of_hour   = o_min_ff;
   assign rsp_hour_of_day      = o_hour_ff;
   assign rsp_day_of_month     = o_mday_ff;
   assign rsp_month_index      = o_month_ff;
   assign rsp_years_since_1900 = o_year_ff;
   assign rsp_day_of_year      = o_yday_ff;

   assign in_div_state = (state_ff == ST_DIV_DAY) || (state_ff == ST_DIV_HOUR)
                         || (state_ff == ST_DIV_MIN);
   assign walk_bounded = (days_ff < 16'd366) && (month_ff <= MonthLast);
   assign time_legal   = (rsp_hour_of_day < 5'd24) && (rsp_minute_of_hour < 6'd60)
                         && (rsp_second_of_minute < 6'd60);

   `ASSERT_NEXT(a_accept_starts_div, clock, reset, req_valid && req_ready, state_ff == ST_DIV_DAY)
   `ASSERT_SAME(a_done_in_div_state, clock, reset, div_res.done, in_div_state)
   `ASSERT_SAME(a_month_walk_bounded, clock, reset, state_ff == ST_MONTH, walk_bounded)
   `ASSERT_SAME(a_time_fields_legal, clock, reset, rsp_valid, time_legal)

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the epoch seconds to civil time converter.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SECONDS_PER_DAY = 86400;
   localparam int FIRST_YEAR      = 1970;
   localparam int YEAR_BASE       = 1900;
   localparam int FEBRUARY        = 1;
   localparam int APRIL           = 3;
   localparam int JUNE            = 5;
   localparam int SEPTEMBER       = 8;
   localparam int NOVEMBER        = 10;
   localparam int DECEMBER        = 11;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = 250;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [4:0] mday;
      logic [3:0] month;
      logic [7:0] year;
      logic [8:0] yday;
   } civil_time_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_epoch_seconds = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [5:0]  rsp_second_of_minute;
   logic [5:0]  rsp_minute_of_hour;
   logic [4:0]  rsp_hour_of_day;
   logic [4:0]  rsp_day_of_month;
   logic [3:0]  rsp_month_index;
   logic [7:0]  rsp_years_since_1900;
   logic [8:0]  rsp_day_of_year;

   civil_time_type civil_expected[$];
   int             mismatch_count = 0;
   int             quiet_cycles_ff = 0;
   int             sender_idle_pct = 0;
   int             receiver_idle_pct = 0;

   epoch_seconds_to_civil_time_top u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_epoch_seconds    (req_epoch_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_second_of_minute (rsp_second_of_minute),
      .rsp_minute_of_hour   (rsp_minute_of_hour),
      .rsp_hour_of_day      (rsp_hour_of_day),
      .rsp_day_of_month     (rsp_day_of_month),
      .rsp_month_index      (rsp_month_index),
      .rsp_years_since_1900 (rsp_years_since_1900),
      .rsp_day_of_year      (rsp_day_of_year)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit is_gregorian_leap(input int year);
      return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
   endfunction

   function automatic int leap_days_through(input int year);
      return year / 4 - year / 100 + year / 400;
   endfunction

   function automatic int days_in_month(input int year, input int month);
      case (month)
         FEBRUARY: return is_gregorian_leap(year) ? 29 : 28;
         APRIL, JUNE, SEPTEMBER, NOVEMBER: return 30;
         default: return 31;
      endcase
   endfunction

   function automatic longint seconds_at(input int year, input int month, input int mday,
                                         input int hour, input int minute, input int sec);
      longint days;
      days = 0;
      for (int y = FIRST_YEAR; y < year; y++) days += is_gregorian_leap(y) ? 366 : 365;
      for (int m = 0; m < month; m++) days += days_in_month(year, m);
      days += mday - 1;
      return days * SECONDS_PER_DAY + hour * 3600 + minute * 60 + sec;
   endfunction

   // The year is estimated from the remaining days and then corrected for leap days.
   function automatic civil_time_type predict_civil_time(input logic [31:0] secs);
      civil_time_type t;
      int             days;
      int             year;
      int             next;
      int             yday;
      int             month;
      int unsigned    tod;
      days = int'(secs / 32'd86400);
      tod  = secs % 32'd86400;
      year = FIRST_YEAR;
      forever begin
         if (days < (is_gregorian_leap(year) ? 366 : 365)) break;
         next = year + days / 366;
         if (next == year) next++;
         days -= (next - year) * 365;
         days += leap_days_through(year - 1) - leap_days_through(next - 1);
         year = next;
      end
      yday  = days;
      month = 0;
      while (month < DECEMBER && days >= days_in_month(year, month)) begin
         days -= days_in_month(year, month);
         month++;
      end
      t.second = 6'(tod % 60);
      t.minute = 6'((tod / 60) % 60);
      t.hour   = 5'(tod / 3600);
      t.mday   = 5'(days + 1);
      t.month  = 4'(month);
      t.year   = 8'(year - YEAR_BASE);
      t.yday   = 9'(yday);
      return t;
   endfunction

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin
      civil_time_type want;
      if (!reset) begin
         if (req_valid && req_ready) civil_expected.push_back(predict_civil_time(req_epoch_seconds));
         if (rsp_valid && rsp_ready) begin
            if (civil_expected.size() == 0) begin
               mismatch_count++;
               $display("%0t: result word with no expected word, actual %0d-%0d-%0d", $time,
                        rsp_years_since_1900, rsp_month_index, rsp_day_of_month);
            end else begin
               want = civil_expected.pop_front();
               check_field("second_of_minute", want.second, rsp_second_of_minute);
               check_field("minute_of_hour", want.minute, rsp_minute_of_hour);
               check_field("hour_of_day", want.hour, rsp_hour_of_day);
               check_field("day_of_month", want.mday, rsp_day_of_month);
               check_field("month_index", want.month, rsp_month_index);
               check_field("years_since_1900", want.year, rsp_years_since_1900);
               check_field("day_of_year", want.yday, rsp_day_of_year);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles_ff <= 0;
      end else begin
         quiet_cycles_ff <= quiet_cycles_ff + 1;
         if (quiet_cycles_ff + 1 >= WATCHDOG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   task automatic send_seconds(input logic [31:0] secs);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         if ($urandom_range(9) == 0) repeat ($urandom_range(1, 220)) @(posedge clock);
         else repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_epoch_seconds <= secs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_civil(input int year, input int month, input int mday,
                             input int hour, input int minute, input int sec);
      longint stamp;
      stamp = seconds_at(year, month, mday, hour, minute, sec);
      send_seconds(stamp[31:0]);
   endtask

   task automatic test_range_extremes();
      send_seconds(32'h0000_0000);
      send_seconds(32'hFFFF_FFFF);
      send_seconds(32'd86399);
      send_seconds(32'd86400);
      send_seconds(32'h7FFF_FFFF);
      send_seconds(32'h8000_0000);
   endtask

   task automatic test_leap_rules();
      send_civil(1972, FEBRUARY, 29, 0, 0, 0);
      send_civil(1972, DECEMBER, 31, 23, 59, 59);
      send_civil(2000, FEBRUARY, 29, 12, 30, 30);
      send_civil(2000, DECEMBER, 31, 23, 59, 59);
      send_civil(2100, FEBRUARY, 28, 23, 59, 59);
      send_civil(2100, FEBRUARY + 1, 1, 0, 0, 0);
      send_civil(2105, DECEMBER, 31, 23, 59, 59);
   endtask

   task automatic test_month_walk();
      for (int m = 0; m <= DECEMBER; m++) send_civil(2024, m, days_in_month(2024, m), 23, 59, 59);
   endtask

   task automatic test_uniform_seconds(input int count);
      repeat (count) send_seconds($urandom);
   endtask

   // Timestamps biased toward the start or end of a day, month or year, up to two seconds either way.
   task automatic test_calendar_edges(input int count);
      longint stamp;
      int     year;
      int     month;
      int     mday;
      int     offset;
      repeat (count) begin
         year  = $urandom_range(FIRST_YEAR, 2106);
         month = $urandom_range(0, DECEMBER);
         mday  = $urandom_range(1) ? 1 : days_in_month(year, month);
         if ($urandom_range(3) == 0) mday = $urandom_range(1, days_in_month(year, month));
         offset = $urandom_range(0, 4);
         stamp = seconds_at(year, month, mday,
                            $urandom_range(1) ? 23 : $urandom_range(0, 23),
                            $urandom_range(1) ? 59 : $urandom_range(0, 59),
                            $urandom_range(1) ? 59 : $urandom_range(0, 59)) + offset - 2;
         if (stamp < 0 || stamp > 64'hFFFF_FFFF) stamp = $urandom;
         send_seconds(stamp[31:0]);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct   = 19;
      receiver_idle_pct = 47;
      test_range_extremes();
      test_leap_rules();
      test_month_walk();
      test_uniform_seconds(350);
      test_calendar_edges(300);

      sender_idle_pct   = 47;
      receiver_idle_pct = 19;
      test_uniform_seconds(350);
      test_calendar_edges(300);

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_uniform_seconds(350);
      test_calendar_edges(300);

      req_valid <= 1'b0;
      while (civil_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && civil_expected.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+design
design/es2ct_pkg.sv
design/es2ct_div.sv
design/epoch_seconds_to_civil_time_top.sv
tb/sv/testbench.sv
